// ----- hdl/skhe_pkg.sv -----
// Package for the selectable key hash engine.
// Holds payload types, register indexes, algorithm codes, hash constants and
// the datapath command set. It depends on nothing.
package skhe_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS = 8;
    localparam int ALG_BITS = 2;
    localparam int BUCKET_BITS_W = 6;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ALGORITHM_SELECT = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUCKET_BITS = 8'd1;

    localparam logic [ALG_BITS-1:0] ALG_FNV = 2'd0;
    localparam logic [ALG_BITS-1:0] ALG_DJB = 2'd1;
    localparam logic [ALG_BITS-1:0] ALG_MURMUR = 2'd2;

    localparam logic [BUCKET_BITS_W-1:0] BUCKET_BITS_RESET = 6'd10;
    localparam logic [BUCKET_BITS_W-1:0] BUCKET_BITS_MAX = 6'd32;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
    localparam logic [63:0] DJB_SEED = 64'd5381;
    localparam logic [63:0] MM_SEED = 64'hdeadbeefcafe1234;
    localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] MM_ADD = 64'h0000000052dce729;
    localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;

    typedef struct packed {
        logic [7:0]             key_byte;
        logic                   byte_present;
        logic [LENGTH_BITS-1:0] key_length;
        logic                   last_of_key;
    } t_in_item;

    typedef struct packed {
        logic [63:0] hash_value;
        logic [31:0] bucket_index;
        logic        length_mismatch;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DJB,
        OP_FNV_SET,
        OP_GATHER,
        OP_BLK_C1,
        OP_ROT_C2,
        OP_HMIX,
        OP_H_ACC,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_KSTATE_F1,
        OP_TAIL_F1,
        OP_FMIX_F2,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        logic [ALG_BITS-1:0] alg;
        logic                present;
        logic                last;
        logic                fill_zero;
        logic                out_free;
    } t_dp_status;

endpackage

// ----- hdl/selectable_key_hash_engine_top.sv -----
// Top level of the selectable key hash engine: configuration registers,
// controller and datapath. Uses skhe_pkg, skhe_ctrl and skhe_dp.
//
// Channel   Direction  Signals                                   Contents
// input     in         i_in_valid, o_in_ready, i_in_data         zero or one key byte
// output    out        o_out_valid, i_out_ready, o_out_data      hash, bucket, mismatch flag
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_index/data register write
//
// An item without a byte or with a DJB2 byte uses no multiply; an FNV-1a byte
// takes one product and a murmur byte that completes an eight-byte block takes
// two, each built by the MUL0, MUL1, MUL2 steps of the shared 32x32 multiplier.
// A last item adds the finish step, and for murmur the tail and mix products.
// Reset is synchronous; a result waits in the output register while the next
// key is taken, and only the final step of a key stalls on a full register.
module selectable_key_hash_engine_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  skhe_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output skhe_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [skhe_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [skhe_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    logic [skhe_pkg::ALG_BITS-1:0]      r_alg_sel;
    logic [skhe_pkg::BUCKET_BITS_W-1:0] r_bucket_bits;
    skhe_pkg::t_dp_op                   op;
    skhe_pkg::t_dp_status               status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg_sel <= skhe_pkg::ALG_FNV;
            r_bucket_bits <= skhe_pkg::BUCKET_BITS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                skhe_pkg::CFG_ALGORITHM_SELECT: begin
                    r_alg_sel <= i_cfg_data[skhe_pkg::ALG_BITS-1:0];
                end
                skhe_pkg::CFG_BUCKET_BITS: begin
                    r_bucket_bits <= i_cfg_data[skhe_pkg::BUCKET_BITS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    skhe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_op       (op)
    );

    skhe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .i_in_data     (i_in_data),
        .i_alg_sel     (r_alg_sel),
        .i_bucket_bits (r_bucket_bits),
        .i_out_ready   (i_out_ready),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

// ----- hdl/skhe_ctrl.sv -----
// Controller of the selectable key hash engine.
// Sequences one datapath command per cycle for each item; uses skhe_pkg.
module skhe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  skhe_pkg::t_dp_status i_status,
    output skhe_pkg::t_dp_op    o_op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_GCHK,
        S_M0,
        S_M1,
        S_M2,
        S_ROT,
        S_HMIX,
        S_FNV_WB,
        S_END,
        S_TROT,
        S_TAILX,
        S_F2,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        o_op = skhe_pkg::OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = skhe_pkg::OP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_status.present) begin
                    n_state = S_END;
                end else if (i_status.alg == skhe_pkg::ALG_DJB) begin
                    o_op = skhe_pkg::OP_DJB;
                    n_state = S_END;
                end else if (i_status.alg == skhe_pkg::ALG_MURMUR) begin
                    o_op = skhe_pkg::OP_GATHER;
                    n_state = S_GCHK;
                end else begin
                    o_op = skhe_pkg::OP_FNV_SET;
                    n_state = S_M0;
                    n_ret = S_FNV_WB;
                end
            end
            S_GCHK: begin
                if (i_status.fill_zero) begin
                    o_op = skhe_pkg::OP_BLK_C1;
                    n_state = S_M0;
                    n_ret = S_ROT;
                end else begin
                    n_state = S_END;
                end
            end
            S_M0: begin
                o_op = skhe_pkg::OP_MUL0;
                n_state = S_M1;
            end
            S_M1: begin
                o_op = skhe_pkg::OP_MUL1;
                n_state = S_M2;
            end
            S_M2: begin
                o_op = skhe_pkg::OP_MUL2;
                n_state = r_ret;
            end
            S_ROT: begin
                o_op = skhe_pkg::OP_ROT_C2;
                n_state = S_M0;
                n_ret = S_HMIX;
            end
            S_HMIX: begin
                o_op = skhe_pkg::OP_HMIX;
                n_state = S_END;
            end
            S_FNV_WB: begin
                o_op = skhe_pkg::OP_H_ACC;
                n_state = S_END;
            end
            S_END: begin
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (i_status.alg != skhe_pkg::ALG_MURMUR) begin
                    n_state = S_FIN;
                end else if (i_status.fill_zero) begin
                    o_op = skhe_pkg::OP_KSTATE_F1;
                    n_state = S_M0;
                    n_ret = S_F2;
                end else begin
                    o_op = skhe_pkg::OP_BLK_C1;
                    n_state = S_M0;
                    n_ret = S_TROT;
                end
            end
            S_TROT: begin
                o_op = skhe_pkg::OP_ROT_C2;
                n_state = S_M0;
                n_ret = S_TAILX;
            end
            S_TAILX: begin
                o_op = skhe_pkg::OP_TAIL_F1;
                n_state = S_M0;
                n_ret = S_F2;
            end
            S_F2: begin
                o_op = skhe_pkg::OP_FMIX_F2;
                n_state = S_M0;
                n_ret = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_op = skhe_pkg::OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- hdl/skhe_dp.sv -----
// Datapath of the selectable key hash engine: key state, a shared 32x32
// multiplier building 64-bit products over the MUL0, MUL1 and MUL2 steps, and the
// result register. Uses skhe_pkg and is driven by skhe_ctrl.
module skhe_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  skhe_pkg::t_dp_op                     i_op,
    input  skhe_pkg::t_in_item                   i_in_data,
    input  logic [skhe_pkg::ALG_BITS-1:0]        i_alg_sel,
    input  logic [skhe_pkg::BUCKET_BITS_W-1:0]   i_bucket_bits,
    input  logic                                 i_out_ready,
    output skhe_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    output skhe_pkg::t_out_item                  o_out_data
);

    localparam int LB = skhe_pkg::LENGTH_BITS;
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

    logic                          r_inprog;
    logic [skhe_pkg::ALG_BITS-1:0] r_alg;
    logic [LB-1:0]                 r_stated;
    logic [LB-1:0]                 r_bytes;
    logic                          r_over;
    logic [63:0]                   r_h;
    logic [63:0]                   r_blk;
    logic [2:0]                    r_fill;
    logic [7:0]                    r_byte;
    logic                          r_present;
    logic                          r_last;
    logic [63:0]                   r_ma;
    logic [63:0]                   r_mb;
    logic [63:0]                   r_acc;
    logic                          r_out_valid;
    skhe_pkg::t_out_item           r_out;

    logic [skhe_pkg::ALG_BITS-1:0] eff_alg;
    logic [LB-1:0]                 bytes_base;
    logic                          over_base;
    logic [31:0]                   mul_x;
    logic [31:0]                   mul_y;
    logic [63:0]                   prod;
    logic [63:0]                   hmix_t;
    logic [63:0]                   kstate_x;
    logic [63:0]                   tail_x;
    logic [63:0]                   fmix_acc;
    logic [63:0]                   res;
    logic [5:0]                    bb;
    logic [32:0]                   mask;
    logic                          out_free;

    assign eff_alg = (i_alg_sel == skhe_pkg::ALG_DJB || i_alg_sel == skhe_pkg::ALG_MURMUR) ?
                     i_alg_sel : skhe_pkg::ALG_FNV;
    assign bytes_base = r_inprog ? r_bytes : '0;
    assign over_base = r_inprog ? r_over : 1'b0;

    always_comb begin
        case (i_op)
            skhe_pkg::OP_MUL1: begin
                mul_x = r_ma[31:0];
                mul_y = r_mb[63:32];
            end
            skhe_pkg::OP_MUL2: begin
                mul_x = r_ma[63:32];
                mul_y = r_mb[31:0];
            end
            default: begin
                mul_x = r_ma[31:0];
                mul_y = r_mb[31:0];
            end
        endcase
    end

    assign prod = 64'(mul_x) * 64'(mul_y);

    assign hmix_t = {(r_h[36:0] ^ r_acc[36:0]), (r_h[63:37] ^ r_acc[63:37])};
    assign kstate_x = r_h ^ 64'(r_stated);
    assign tail_x = r_h ^ r_acc ^ 64'(r_stated);
    assign fmix_acc = r_acc ^ (r_acc >> 33);

    assign res = (r_alg == skhe_pkg::ALG_MURMUR) ? fmix_acc : r_h;
    assign bb = (i_bucket_bits > skhe_pkg::BUCKET_BITS_MAX) ? skhe_pkg::BUCKET_BITS_MAX :
                i_bucket_bits;
    assign mask = (33'd1 << bb) - 33'd1;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inprog <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == skhe_pkg::OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                skhe_pkg::OP_LOAD: begin
                    r_inprog <= 1'b1;
                end
                skhe_pkg::OP_FINISH: begin
                    r_inprog <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            skhe_pkg::OP_LOAD: begin
                r_byte <= i_in_data.key_byte;
                r_present <= i_in_data.byte_present;
                r_last <= i_in_data.last_of_key;
                if (!r_inprog) begin
                    r_alg <= eff_alg;
                    r_stated <= i_in_data.key_length;
                    r_blk <= '0;
                    r_fill <= '0;
                    case (eff_alg)
                        skhe_pkg::ALG_DJB: r_h <= skhe_pkg::DJB_SEED;
                        skhe_pkg::ALG_MURMUR: r_h <= skhe_pkg::MM_SEED ^
                                                     64'(i_in_data.key_length);
                        default: r_h <= skhe_pkg::FNV_BASIS;
                    endcase
                end
                if (i_in_data.byte_present) begin
                    r_bytes <= (bytes_base == LEN_MAX) ? bytes_base : bytes_base + 1'b1;
                    r_over <= over_base | (bytes_base == LEN_MAX);
                end else begin
                    r_bytes <= bytes_base;
                    r_over <= over_base;
                end
            end
            skhe_pkg::OP_DJB: begin
                r_h <= (r_h << 5) + r_h + 64'(r_byte);
            end
            skhe_pkg::OP_FNV_SET: begin
                r_ma <= r_h ^ 64'(r_byte);
                r_mb <= skhe_pkg::FNV_PRIME;
            end
            skhe_pkg::OP_GATHER: begin
                r_blk <= r_blk | (64'(r_byte) << {r_fill, 3'b000});
                r_fill <= r_fill + 3'd1;
            end
            skhe_pkg::OP_BLK_C1: begin
                r_ma <= r_blk;
                r_mb <= skhe_pkg::MM_C1;
                r_blk <= '0;
            end
            skhe_pkg::OP_ROT_C2: begin
                r_ma <= {r_acc[32:0], r_acc[63:33]};
                r_mb <= skhe_pkg::MM_C2;
            end
            skhe_pkg::OP_HMIX: begin
                r_h <= (hmix_t << 2) + hmix_t + skhe_pkg::MM_ADD;
            end
            skhe_pkg::OP_H_ACC: begin
                r_h <= r_acc;
            end
            skhe_pkg::OP_MUL0: begin
                r_acc <= prod;
            end
            skhe_pkg::OP_MUL1, skhe_pkg::OP_MUL2: begin
                r_acc <= r_acc + {prod[31:0], 32'd0};
            end
            skhe_pkg::OP_KSTATE_F1: begin
                r_ma <= kstate_x ^ (kstate_x >> 33);
                r_mb <= skhe_pkg::MM_F1;
            end
            skhe_pkg::OP_TAIL_F1: begin
                r_ma <= tail_x ^ (tail_x >> 33);
                r_mb <= skhe_pkg::MM_F1;
                r_fill <= '0;
            end
            skhe_pkg::OP_FMIX_F2: begin
                r_ma <= fmix_acc;
                r_mb <= skhe_pkg::MM_F2;
            end
            skhe_pkg::OP_FINISH: begin
                r_out.hash_value <= res;
                r_out.bucket_index <= res[31:0] & mask[31:0];
                r_out.length_mismatch <= r_over || (r_bytes != r_stated);
                r_h <= '0;
                r_blk <= '0;
                r_fill <= '0;
            end
            default: begin
            end
        endcase
    end

    assign o_status.alg = r_alg;
    assign o_status.present = r_present;
    assign o_status.last = r_last;
    assign o_status.fill_zero = (r_fill == 3'd0);
    assign o_status.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule
